// File: src/byte_ring_queue_overwrite_defines.svh
// ----------------------------------------------------------------------------
// Byte ring queue assertion macros
// Shared property macros for the checker of the byte ring queue.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_QUEUE_OVERWRITE_DEFINES_SVH
`define BYTE_RING_QUEUE_OVERWRITE_DEFINES_SVH

// Same-cycle implication, sampled on clock and quiet while reset is high.
`define BRQO_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, checked through reset as well.
`define BRQO_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/brqo_pkg.sv
// ----------------------------------------------------------------------------
// Byte ring queue package
// Request codes, field widths and the command and response beat types.
// ----------------------------------------------------------------------------
package brqo_pkg;

   localparam int CSR_W   = 11;
   localparam int DATA_W  = 8;
   localparam int COUNT_W = 10;
   localparam int REQ_W   = 2;

   localparam logic [CSR_W-1:0] SLOTS_RESET = 11'd1024;

   localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_FLUSH  = 2'd2;
   localparam logic [REQ_W-1:0] REQ_STATUS = 2'd3;

   // A decoded request; all flags low means a status query.
   typedef struct packed {
      logic              is_push;
      logic              is_pop;
      logic              is_flush;
      logic [DATA_W-1:0] data;
   } cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0]  pop_data;
      logic [DATA_W-1:0]  head_data;
      logic [COUNT_W-1:0] stored_count;
      logic               is_empty;
      logic               is_full;
      logic               dropped_oldest;
      logic               pop_was_empty;
   } rsp_type;

endpackage

// File: src/brqo_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module brqo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/brqo_front.sv
// ----------------------------------------------------------------------------
// Byte ring queue front end
// Accepts request beats, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module brqo_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [brqo_pkg::REQ_W-1:0]  req_type,
   input  logic [brqo_pkg::DATA_W-1:0] req_push_data,
   output logic                        cmd_valid,
   output brqo_pkg::cmd_type           cmd,
   input  logic                        cmd_take
);
   import brqo_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       accept;
   cmd_type    new_cmd;

   assign busy   = (fill_ff == 2'd2);
   assign accept = start && !busy;

   always_comb begin
      new_cmd      = '0;
      new_cmd.data = req_push_data;
      case (req_type)
         REQ_PUSH:   new_cmd.is_push  = 1'b1;
         REQ_POP:    new_cmd.is_pop   = 1'b1;
         REQ_FLUSH:  new_cmd.is_flush = 1'b1;
         REQ_STATUS: new_cmd          = new_cmd;
         default:    new_cmd          = new_cmd;
      endcase
   end

   always_comb begin
      wr_ptr_in = accept   ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_take ? ~rd_ptr_ff : rd_ptr_ff;
      case ({accept, cmd_take})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

endmodule

// File: src/brqo_back.sv
// ----------------------------------------------------------------------------
// Byte ring queue back end
// Sequencer that updates the ring indices, the byte store and the response.
// ----------------------------------------------------------------------------
module brqo_back #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [brqo_pkg::CSR_W-1:0] slots_cfg,
   input  logic                       cmd_valid,
   input  brqo_pkg::cmd_type          cmd,
   output logic                       cmd_take,
   output brqo_pkg::rsp_type          rsp,
   output logic                       rsp_strobe
);
   import brqo_pkg::*;

   localparam int IDX_W = $clog2(MAX_SLOTS);
   localparam int LEN_W = $clog2(MAX_SLOTS + 1);
   localparam int CW    = (LEN_W > CSR_W) ? LEN_W : CSR_W;
   localparam int CNT_W = $clog2(IDX_W + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_EXEC   = 3'd2;
   localparam logic [2:0] ST_POPRD  = 3'd3;
   localparam logic [2:0] ST_HEADRD = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [IDX_W-1:0]  rd_ff, rd_in;
   logic [IDX_W-1:0]  wr_ff, wr_in;
   logic              strobe_ff, strobe_in;
   cmd_type           cmd_ff, cmd_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  rrem_ff, rrem_in;
   logic [LEN_W-1:0]  wrem_ff, wrem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              drop_ff, drop_in;
   logic              pope_ff, pope_in;
   logic              popv_ff, popv_in;
   logic [DATA_W-1:0] popd_ff, popd_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   rsp_type           rsp_ff, rsp_in;

   logic [CW-1:0]     slots_ext;
   logic [LEN_W-1:0]  len_c;
   logic [LEN_W-1:0]  rrem_step, wrem_step;
   logic              ram_we;
   logic [DATA_W-1:0] ram_q;

   // One restoring step of index modulo ring length.
   function automatic logic [LEN_W-1:0] rem_step(input logic [LEN_W-1:0] rem,
                                                input logic             din,
                                                input logic [LEN_W-1:0] len);
      logic [LEN_W:0] trial;
      trial = {rem, din};
      if (trial >= {1'b0, len}) begin
         trial = trial - {1'b0, len};
      end
      return trial[LEN_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] idx,
                                           input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] nx;
      nx = LEN_W'(idx) + LEN_W'(1);
      return (nx == len) ? '0 : IDX_W'(nx);
   endfunction

   always_comb begin
      slots_ext = CW'(slots_cfg);
      if (slots_ext < CW'(2)) begin
         len_c = LEN_W'(2);
      end else if (slots_ext > CW'(MAX_SLOTS)) begin
         len_c = LEN_W'(MAX_SLOTS);
      end else begin
         len_c = LEN_W'(slots_ext);
      end
   end

   assign rrem_step = rem_step(rrem_ff, rd_ff[IDX_W-1], len_ff);
   assign wrem_step = rem_step(wrem_ff, wr_ff[IDX_W-1], len_ff);
   assign cmd_take  = (state_ff == ST_IDLE) && cmd_valid;
   assign ram_we    = (state_ff == ST_EXEC) && cmd_ff.is_push;

   always_comb begin
      state_in  = state_ff;
      rd_in     = rd_ff;
      wr_in     = wr_ff;
      strobe_in = 1'b0;
      cmd_in    = cmd_ff;
      len_in    = len_ff;
      rrem_in   = rrem_ff;
      wrem_in   = wrem_ff;
      cnt_in    = cnt_ff;
      drop_in   = drop_ff;
      pope_in   = pope_ff;
      popv_in   = popv_ff;
      popd_in   = popd_ff;
      count_in  = count_ff;
      rsp_in    = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in  = cmd;
               len_in  = len_c;
               drop_in = 1'b0;
               pope_in = 1'b0;
               popv_in = 1'b0;
               if ((LEN_W'(rd_ff) >= len_c) || (LEN_W'(wr_ff) >= len_c)) begin
                  rrem_in  = '0;
                  wrem_in  = '0;
                  cnt_in   = CNT_W'(IDX_W - 1);
                  state_in = ST_REDUCE;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_REDUCE: begin
            // Indices are shifted out msb first into the remainders.
            if (cnt_ff == '0) begin
               rd_in    = IDX_W'(rrem_step);
               wr_in    = IDX_W'(wrem_step);
               state_in = ST_EXEC;
            end else begin
               rrem_in = rrem_step;
               wrem_in = wrem_step;
               rd_in   = rd_ff << 1;
               wr_in   = wr_ff << 1;
               cnt_in  = cnt_ff - CNT_W'(1);
            end
         end
         ST_EXEC: begin
            if (cmd_ff.is_push) begin
               if (adv(wr_ff, len_ff) == rd_ff) begin
                  rd_in   = adv(rd_ff, len_ff);
                  drop_in = 1'b1;
               end
               wr_in = adv(wr_ff, len_ff);
            end else if (cmd_ff.is_pop) begin
               if (rd_ff == wr_ff) begin
                  pope_in = 1'b1;
               end else begin
                  popv_in = 1'b1;
                  rd_in   = adv(rd_ff, len_ff);
               end
            end else if (cmd_ff.is_flush) begin
               rd_in = '0;
               wr_in = '0;
            end
            state_in = ST_POPRD;
         end
         ST_POPRD: begin
            popd_in = popv_ff ? ram_q : '0;
            if (wr_ff >= rd_ff) begin
               count_in = LEN_W'(wr_ff) - LEN_W'(rd_ff);
            end else begin
               count_in = LEN_W'(wr_ff) + len_ff - LEN_W'(rd_ff);
            end
            state_in = ST_HEADRD;
         end
         ST_HEADRD: begin
            rsp_in.pop_data       = popd_ff;
            rsp_in.head_data      = (count_ff != '0) ? ram_q : '0;
            rsp_in.stored_count   = COUNT_W'(count_ff);
            rsp_in.is_empty       = (count_ff == '0);
            rsp_in.is_full        = (count_ff == (len_ff - LEN_W'(1)));
            rsp_in.dropped_oldest = drop_ff;
            rsp_in.pop_was_empty  = pope_ff;
            strobe_in             = 1'b1;
            state_in              = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_ff     <= '0;
         wr_ff     <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_ff     <= rd_in;
         wr_ff     <= wr_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      len_ff   <= len_in;
      rrem_ff  <= rrem_in;
      wrem_ff  <= wrem_in;
      cnt_ff   <= cnt_in;
      drop_ff  <= drop_in;
      pope_ff  <= pope_in;
      popv_ff  <= popv_in;
      popd_ff  <= popd_in;
      count_ff <= count_in;
      rsp_ff   <= rsp_in;
   end

   brqo_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ff),
      .wr_data (cmd_ff.data),
      .rd_addr (rd_ff),
      .rd_data (ram_q)
   );

   assign rsp        = rsp_ff;
   assign rsp_strobe = strobe_ff;

endmodule

// File: src/byte_ring_queue_overwrite.sv
// ----------------------------------------------------------------------------
// Byte ring queue with overwrite of the oldest byte
// Top level: slot count register, request front end and execution back end.
// ----------------------------------------------------------------------------
// A request beat is taken on a rising edge with start high and busy low, and
// exactly one response beat comes back for it, in request order, with
// rsp_strobe high for a single cycle; the receiver cannot hold it off, so it
// must take every strobed beat. In the back end a request passes through
// command pickup, execute with the store write or pop read, then the
// registered read of the new head byte. The back-end sequencer and the single
// read port of the byte store let the back end take a new request only once
// it has finished the last one. A two-entry queue between the front end and
// the back end lets up to two requests wait; busy is high while both entries
// are occupied. If a ring index lies outside the ring length, as after a slot
// count change without a flush, the next request first reduces both ring
// indices modulo the new ring length one bit per cycle. Write csr_wdata only
// while no request is outstanding, and flush after changing it.
// ----------------------------------------------------------------------------
module byte_ring_queue_overwrite #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   // Request channel.
   input  logic                         start,
   output logic                         busy,
   input  logic [brqo_pkg::REQ_W-1:0]   req_type,
   input  logic [brqo_pkg::DATA_W-1:0]  req_push_data,
   // Response channel.
   output logic                         rsp_strobe,
   output logic [brqo_pkg::DATA_W-1:0]  rsp_pop_data,
   output logic [brqo_pkg::DATA_W-1:0]  rsp_head_data,
   output logic [brqo_pkg::COUNT_W-1:0] rsp_stored_count,
   output logic                         rsp_is_empty,
   output logic                         rsp_is_full,
   output logic                         rsp_dropped_oldest,
   output logic                         rsp_pop_was_empty,
   // Slot count register.
   input  logic                         csr_we,
   input  logic [brqo_pkg::CSR_W-1:0]   csr_wdata
);
   import brqo_pkg::*;

   // Ring length register; values outside 2..MAX_SLOTS are clamped in the
   // back end when a request is picked up.
   logic [CSR_W-1:0] slots_ff, slots_in;

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;
   rsp_type rsp;

   assign slots_in = csr_we ? csr_wdata : slots_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= SLOTS_RESET;
      end else begin
         slots_ff <= slots_in;
      end
   end

   // The front end decodes request beats and buffers them.
   brqo_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_push_data (req_push_data),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_take      (cmd_take)
   );

   // The back end owns the indices and the byte store and builds responses.
   brqo_back #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .slots_cfg  (slots_ff),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_take   (cmd_take),
      .rsp        (rsp),
      .rsp_strobe (rsp_strobe)
   );

   assign rsp_pop_data       = rsp.pop_data;
   assign rsp_head_data      = rsp.head_data;
   assign rsp_stored_count   = rsp.stored_count;
   assign rsp_is_empty       = rsp.is_empty;
   assign rsp_is_full        = rsp.is_full;
   assign rsp_dropped_oldest = rsp.dropped_oldest;
   assign rsp_pop_was_empty  = rsp.pop_was_empty;

endmodule

// File: src/brqo_checker.sv
// ----------------------------------------------------------------------------
// Byte ring queue checker
// Port-level assertions on response beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "byte_ring_queue_overwrite_defines.svh"

module brqo_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_strobe,
   input logic [brqo_pkg::DATA_W-1:0]  rsp_pop_data,
   input logic [brqo_pkg::DATA_W-1:0]  rsp_head_data,
   input logic [brqo_pkg::COUNT_W-1:0] rsp_stored_count,
   input logic                         rsp_is_empty,
   input logic                         rsp_is_full,
   input logic                         rsp_dropped_oldest,
   input logic                         rsp_pop_was_empty
);

   logic empty_beat;
   logic empty_view_ok;
   logic drop_beat;
   logic drop_view_ok;
   logic pop_empty_beat;
   logic pop_empty_ok;

   assign empty_beat     = rsp_strobe && rsp_is_empty;
   assign empty_view_ok  = (rsp_stored_count == '0) && (rsp_head_data == '0) && !rsp_is_full;
   assign drop_beat      = rsp_strobe && rsp_dropped_oldest;
   assign drop_view_ok   = rsp_is_full && !rsp_pop_was_empty && (rsp_pop_data == '0);
   assign pop_empty_beat = rsp_strobe && rsp_pop_was_empty;
   assign pop_empty_ok   = rsp_is_empty && (rsp_pop_data == '0) && !rsp_dropped_oldest;

   // An empty queue reports no bytes and no head byte.
   `BRQO_ASSERT_IMPL(a_empty_view, empty_beat, empty_view_ok, "empty beat shows stored data")

   // Dropping the oldest byte only happens on a push into a full queue.
   `BRQO_ASSERT_IMPL(a_drop_full, drop_beat, drop_view_ok, "drop without a full queue")

   // A pop on an empty queue returns zero and leaves the queue empty.
   `BRQO_ASSERT_IMPL(a_pop_empty, pop_empty_beat, pop_empty_ok, "empty pop moved data")

   // No response beat follows reset directly.
   `BRQO_ASSERT_NEXT(a_reset_quiet, reset, !rsp_strobe, "response beat right after reset")

endmodule

bind byte_ring_queue_overwrite brqo_checker u_brqo_checker (.*);

// File: verif/brqo_reply_checker.sv
// ----------------------------------------------------------------------------
// Byte ring queue response checker
// Watches the request, response and slot count ports of the byte ring queue,
// predicts the response beat of every accepted request and compares it with
// the beat that comes back. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module brqo_reply_checker #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [brqo_pkg::REQ_W-1:0]   req_type,
   input  logic [brqo_pkg::DATA_W-1:0]  req_push_data,
   input  logic                         rsp_strobe,
   input  logic [brqo_pkg::DATA_W-1:0]  rsp_pop_data,
   input  logic [brqo_pkg::DATA_W-1:0]  rsp_head_data,
   input  logic [brqo_pkg::COUNT_W-1:0] rsp_stored_count,
   input  logic                         rsp_is_empty,
   input  logic                         rsp_is_full,
   input  logic                         rsp_dropped_oldest,
   input  logic                         rsp_pop_was_empty,
   input  logic                         csr_we,
   input  logic [brqo_pkg::CSR_W-1:0]   csr_wdata,
   output int unsigned                  mismatch_count,
   output int unsigned                  outstanding
);
   import brqo_pkg::*;

   localparam int REPORT_LIMIT = 10;
   localparam int IDX_W        = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

   // Shadow copy of the queue state.
   logic [DATA_W-1:0] ring_mem [MAX_SLOTS];
   int unsigned       rd_ptr;
   int unsigned       wr_ptr;
   logic [CSR_W-1:0]  slot_reg;

   rsp_type expected_replies [$];

   function automatic int unsigned ring_step(int unsigned idx, int unsigned len);
      return (idx + 1 >= len) ? 0 : idx + 1;
   endfunction

   // Applies one request to the shadow state and returns the response beat it
   // must produce.
   function automatic rsp_type predict_reply(logic [REQ_W-1:0] kind,
                                             logic [DATA_W-1:0] data);
      int unsigned len;
      int unsigned held;
      rsp_type     r;
      len = 32'(slot_reg);
      if (len < 2) len = 2;
      if (len > MAX_SLOTS) len = MAX_SLOTS;
      r = '0;
      // A stale index left by a slot count change folds into the new ring.
      rd_ptr = rd_ptr % len;
      wr_ptr = wr_ptr % len;
      case (kind)
         REQ_PUSH: begin
            if (ring_step(wr_ptr, len) == rd_ptr) begin
               rd_ptr = ring_step(rd_ptr, len);
               r.dropped_oldest = 1'b1;
            end
            ring_mem[IDX_W'(wr_ptr)] = data;
            wr_ptr = ring_step(wr_ptr, len);
         end
         REQ_POP: begin
            if (rd_ptr == wr_ptr) begin
               r.pop_was_empty = 1'b1;
            end else begin
               r.pop_data = ring_mem[IDX_W'(rd_ptr)];
               rd_ptr = ring_step(rd_ptr, len);
            end
         end
         REQ_FLUSH: begin
            rd_ptr = 0;
            wr_ptr = 0;
         end
         default: ;
      endcase
      held = (len - rd_ptr + wr_ptr) % len;
      r.head_data    = (held != 0) ? ring_mem[IDX_W'(rd_ptr)] : '0;
      r.stored_count = held[COUNT_W-1:0];
      r.is_empty     = (held == 0);
      r.is_full      = (held == len - 1);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rd_ptr         = 0;
         wr_ptr         = 0;
         slot_reg       = SLOTS_RESET;
         mismatch_count = 0;
         expected_replies.delete();
      end else begin
         // Responses first: a beat leaving now belongs to an earlier request.
         if (rsp_strobe) begin
            got.pop_data       = rsp_pop_data;
            got.head_data      = rsp_head_data;
            got.stored_count   = rsp_stored_count;
            got.is_empty       = rsp_is_empty;
            got.is_full        = rsp_is_full;
            got.dropped_oldest = rsp_dropped_oldest;
            got.pop_was_empty  = rsp_pop_was_empty;
            if (expected_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("Response beat arrived with no request outstanding.");
            end else begin
               want = expected_replies.pop_front();
               if (got.pop_data !== want.pop_data || got.head_data !== want.head_data ||
                   got.stored_count !== want.stored_count ||
                   got.is_empty !== want.is_empty || got.is_full !== want.is_full ||
                   got.dropped_oldest !== want.dropped_oldest ||
                   got.pop_was_empty !== want.pop_was_empty) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("Response mismatch (expected/actual): pop %h/%h head %h/%h",
                              want.pop_data, got.pop_data, want.head_data, got.head_data,
                              " count %0d/%0d empty %b/%b full %b/%b",
                              want.stored_count, got.stored_count,
                              want.is_empty, got.is_empty, want.is_full, got.is_full,
                              " drop %b/%b pop_empty %b/%b",
                              want.dropped_oldest, got.dropped_oldest,
                              want.pop_was_empty, got.pop_was_empty);
               end
            end
         end
         if (csr_we)
            slot_reg = csr_wdata;
         if (start && !busy)
            expected_replies.push_back(predict_reply(req_type, req_push_data));
      end
      outstanding = expected_replies.size();
   end

endmodule

// File: verif/byte_ring_queue_overwrite_test.sv
// ----------------------------------------------------------------------------
// Byte ring queue testbench
// Drives push, pop, flush and status requests into the byte ring queue over
// many slot count settings, with random sender gaps, and lets the response
// checker predict and compare every response beat.
// ----------------------------------------------------------------------------
module byte_ring_queue_overwrite_test;
   import brqo_pkg::*;

   localparam int MAX_SLOTS    = 1024;
   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 8;
   // Cycles without any accepted beat before the run is declared hung. The
   // slowest correct beat comes with index folding after a slot count change,
   // and sender gaps are short.
   localparam int STALL_LIMIT  = 2000;
   // Quiet cycles before a slot count write and after the last response.
   localparam int HOLD_OFF     = 8;
   localparam int SETTLE       = 20;
   localparam int TOTAL_ITEMS  = 2000;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [REQ_W-1:0]    req_type;
   logic [DATA_W-1:0]   req_push_data;
   logic                rsp_strobe;
   logic [DATA_W-1:0]   rsp_pop_data;
   logic [DATA_W-1:0]   rsp_head_data;
   logic [COUNT_W-1:0]  rsp_stored_count;
   logic                rsp_is_empty;
   logic                rsp_is_full;
   logic                rsp_dropped_oldest;
   logic                rsp_pop_was_empty;
   logic                csr_we;
   logic [CSR_W-1:0]    csr_wdata;

   int unsigned mismatch_count;
   int unsigned outstanding;
   int unsigned items_sent;
   int unsigned idle_pct;
   int unsigned stall_cycles;

   always #(HALF_PERIOD) clock = ~clock;

   byte_ring_queue_overwrite #(.MAX_SLOTS(MAX_SLOTS)) i_dut (.*);

   brqo_reply_checker #(.MAX_SLOTS(MAX_SLOTS)) i_checker (.*);

   // Sends one request beat. Random idle cycles go in front of it, with junk
   // on the request fields so that the block must ignore them. Start stays
   // high after the beat is taken; the next call either keeps it high or
   // lowers it at its first idle cycle, so it is never toggled within a step.
   task automatic send_request(input logic [REQ_W-1:0] kind, input logic [DATA_W-1:0] data);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start         <= 1'b0;
         req_type      <= REQ_W'($urandom);
         req_push_data <= DATA_W'($urandom);
      end
      @(negedge clock);
      start         <= 1'b1;
      req_type      <= kind;
      req_push_data <= data;
      do @(posedge clock); while (busy);
      items_sent++;
      // The sender idles often at first, more often in the middle third, and
      // not at all in the final third of the run.
      idle_pct = (items_sent < TOTAL_ITEMS / 3) ? 36 :
                 (items_sent < 2 * TOTAL_ITEMS / 3) ? 65 : 0;
   endtask

   // Holds the sender off until every response beat has come back.
   task automatic drain_replies();
      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // The slot count may only change while nothing is in flight.
   task automatic write_slot_count(input logic [CSR_W-1:0] value);
      drain_replies();
      repeat (HOLD_OFF) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // A random request, biased toward pushes so that small rings fill up and
   // start dropping their oldest byte.
   task automatic send_random_request();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 50)
         send_request(REQ_PUSH, DATA_W'($urandom_range(255)));
      else if (pick < 80)
         send_request(REQ_POP, DATA_W'($urandom_range(255)));
      else if (pick < 92)
         send_request(REQ_STATUS, DATA_W'($urandom_range(255)));
      else
         send_request(REQ_FLUSH, DATA_W'($urandom_range(255)));
   endtask

   // Watchdog: ends the run if no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      logic [CSR_W-1:0] slots;
      int unsigned      seg_len;
      reset         = 1'b1;
      start         = 1'b0;
      req_type      = REQ_PUSH;
      req_push_data = '0;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      items_sent    = 0;
      idle_pct      = 36;
      stall_cycles  = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. A register value of zero acts as a two-slot ring that
      // holds one byte: status and pop on an empty queue, a push that fills
      // it, pushes that drop the oldest byte, and pops back to empty.
      write_slot_count(11'd0);
      send_request(REQ_STATUS, 8'h00);
      send_request(REQ_POP, 8'hFF);
      send_request(REQ_PUSH, 8'h00);
      send_request(REQ_STATUS, 8'hFF);
      send_request(REQ_PUSH, 8'hFF);
      send_request(REQ_POP, 8'h00);
      send_request(REQ_POP, 8'h00);
      send_request(REQ_PUSH, 8'hA5);
      send_request(REQ_PUSH, 8'h5A);
      // Flush with bytes held, then check that the queue reads as empty.
      send_request(REQ_FLUSH, 8'hFF);
      send_request(REQ_STATUS, 8'h00);
      send_request(REQ_POP, 8'h00);
      // A value of one is also below the range and clamps to two slots.
      write_slot_count(11'd1);
      send_request(REQ_FLUSH, 8'h00);
      send_request(REQ_PUSH, 8'h3C);
      send_request(REQ_PUSH, 8'hC3);
      // Three slots: fill to two bytes, then drop the oldest.
      write_slot_count(11'd3);
      send_request(REQ_FLUSH, 8'h00);
      send_request(REQ_PUSH, 8'h01);
      send_request(REQ_PUSH, 8'h02);
      send_request(REQ_PUSH, 8'h03);
      send_request(REQ_POP, 8'h00);
      send_request(REQ_STATUS, 8'h00);
      // Above the range: clamps to the largest ring.
      write_slot_count(11'd1025);
      send_request(REQ_FLUSH, 8'h00);
      send_request(REQ_PUSH, 8'h80);
      send_request(REQ_PUSH, 8'h7F);
      send_request(REQ_POP, 8'h00);

      // Fill pass with the register at all ones (largest ring). Pushing past
      // a full lap writes every slot of the store, so later slot count
      // changes without a flush can never read a byte that was never written.
      write_slot_count(11'h7FF);
      send_request(REQ_FLUSH, 8'h00);
      repeat (MAX_SLOTS + $urandom_range(4, 16))
         send_request(REQ_PUSH, DATA_W'($urandom_range(255)));
      repeat ($urandom_range(5, 20))
         send_random_request();

      // Random part: one segment per slot count setting. Most rings are small
      // so they fill and wrap often; some sit at or past the extremes. About
      // half of the changes skip the flush, which makes the block fold stale
      // indices into the new ring.
      while (items_sent < TOTAL_ITEMS) begin
         case ($urandom_range(9))
            0:       slots = CSR_W'($urandom_range(0, 1));
            1:       slots = 11'd2;
            2:       slots = 11'd1024;
            3:       slots = CSR_W'($urandom_range(1025, 2047));
            4:       slots = CSR_W'($urandom_range(18, 1023));
            default: slots = CSR_W'($urandom_range(3, 17));
         endcase
         write_slot_count(slots);
         if ($urandom_range(1) != 0)
            send_request(REQ_FLUSH, DATA_W'($urandom_range(255)));
         seg_len = $urandom_range(20, 60);
         repeat (seg_len) begin
            // Now and then the sender waits for every response beat.
            if ($urandom_range(49) == 0)
               drain_replies();
            send_random_request();
         end
      end

      // Let the last response beats come back, then give the verdict.
      drain_replies();
      repeat (SETTLE) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
